### hw/rtl/ledc_pkg.sv
// Shared types, constants and helpers for the addressable LED chain driver.
// Depends on nothing; every other RTL file of the block uses it by scoped names.
package ledc_pkg;

   localparam int MAX_LEDS = 256;
   localparam int LED_W    = 8;
   localparam int CNT_W    = 9;
   localparam int BYTE_W   = 8;
   localparam int ROW_W    = 3 * BYTE_W;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 20;

   // Command codes of the input transfer.
   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_WRITE_COLOR = 3'd1;
   localparam logic [2:0] CMD_WRITE_PIXEL = 3'd2;
   localparam logic [2:0] CMD_CLEAR       = 3'd3;
   localparam logic [2:0] CMD_SHOW        = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [CSR_AW-1:0] REG_LED_COUNT    = 3'd0;
   localparam logic [CSR_AW-1:0] REG_BIT_PERIOD   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_ZERO_HIGH    = 3'd2;
   localparam logic [CSR_AW-1:0] REG_ONE_HIGH     = 3'd3;
   localparam logic [CSR_AW-1:0] REG_LATCH_CYCLES = 3'd4;

   // Byte slot that is not part of an LED.
   localparam logic [1:0] SLOT_NONE = 2'd3;

   typedef struct packed {
      logic [2:0]        command;
      logic [LED_W-1:0]  led_index;
      logic [1:0]        color_slot;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic write_error;
      logic busy_res;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] led_count;
      logic [15:0]      bit_period;
      logic [15:0]      zero_high;
      logic [15:0]      one_high;
      logic [19:0]      latch_cycles;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      led_count:    9'd256,
      bit_period:   16'd125,
      zero_high:    16'd35,
      one_high:     16'd70,
      latch_cycles: 20'd8000
   };

   // Commands from the top level to the pulse engine.
   typedef struct packed {
      logic advance;
      logic set_dirty;
   } eng_ctl_type;

   // Status from the pulse engine to the top level.
   typedef struct packed {
      logic             line_level;
      logic             busy;
      logic             in_data;
      logic [LED_W-1:0] led_pos;
   } eng_stat_type;

   // Number of LEDs actually sent: the register value is limited to the store size.
   function automatic logic [CNT_W-1:0] chain_len(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] lim;
      lim = CNT_W'(MAX_LEDS);
      return (cnt > lim) ? lim : cnt;
   endfunction

endpackage

### hw/rtl/addressable_led_chain_driver_top.sv
// Top level of the addressable LED chain driver: handshakes, configuration registers,
// command sequencing and the result register. Depends on ledc_pkg, ledc_pixel_store
// and ledc_pulse_engine.
//
//   Channel  Ports                         Direction  Content
//   request  req_valid/req_ready/req_data  in         one command (tick, write, clear, show)
//   response rsp_valid/rsp_ready/rsp_data  out        line level, write error, busy
//   csr      csr_we/csr_index/csr_wdata    in         register write, no wait, no read-back
//
// Ticks, pixel writes, clear-all and show complete in ST_RUN. A single-color write
// reads the row from the pixel memory and writes it back merged in ST_MERGE.
// While sending, the engine needs the row of its current LED in a local register;
// each time the LED position moves, or after any store write, that row is fetched
// before the next command is taken: ST_RUN notices the stale row, ST_FILL reads it
// and ST_LOAD loads it, and the request side stalls meanwhile.
// Reset is synchronous; after it every row reads as zero, with no clearing pass.
// A waiting result does not stop the next transfer as long as rsp_ready is high.
module addressable_led_chain_driver_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ledc_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ledc_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [ledc_pkg::CSR_AW-1:0]    csr_index,
   input  logic [ledc_pkg::CSR_DW-1:0]    csr_wdata
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FILL,
      ST_LOAD,
      ST_MERGE
   } state_type;

   state_type                   state_ff, state_in;
   ledc_pkg::cfg_type           cfg_ff;
   logic                        row_ok_ff, row_ok_in;
   logic [ledc_pkg::LED_W-1:0]  row_pos_ff, row_pos_in;
   logic [ledc_pkg::ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [ledc_pkg::LED_W-1:0]  mrg_idx_ff, mrg_idx_in;
   logic [1:0]                  mrg_slot_ff, mrg_slot_in;
   logic [ledc_pkg::BYTE_W-1:0] mrg_val_ff, mrg_val_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ledc_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   ledc_pkg::eng_ctl_type       eng_ctl;
   ledc_pkg::eng_stat_type      eng_stat;

   logic [ledc_pkg::LED_W-1:0]  rd_addr;
   logic [ledc_pkg::ROW_W-1:0]  rd_row;
   logic                        wr_en;
   logic [ledc_pkg::LED_W-1:0]  wr_addr;
   logic [ledc_pkg::ROW_W-1:0]  wr_row;
   logic [ledc_pkg::ROW_W-1:0]  merged_row;
   logic                        clr_en;

   logic [ledc_pkg::CNT_W-1:0]  len;
   logic                        accept;
   logic                        row_ready;
   logic                        idx_ok;
   logic                        color_ok;
   logic                        is_color;
   logic                        is_pixel;
   logic                        is_clear;
   logic                        write_err;

   assign len      = ledc_pkg::chain_len(cfg_ff.led_count);
   assign is_color = (req_data.command == ledc_pkg::CMD_WRITE_COLOR);
   assign is_pixel = (req_data.command == ledc_pkg::CMD_WRITE_PIXEL);
   assign is_clear = (req_data.command == ledc_pkg::CMD_CLEAR);
   assign idx_ok   = ({1'b0, req_data.led_index} < len);
   assign color_ok = idx_ok && (req_data.color_slot != ledc_pkg::SLOT_NONE);
   assign write_err = (is_color && !color_ok) || (is_pixel && !idx_ok);

   // During data the line level comes from the row of the current LED, so a
   // transfer waits until that row sits in the local register.
   assign row_ready = !eng_stat.in_data || (row_ok_ff && (row_pos_ff == eng_stat.led_pos));
   assign req_ready = (state_ff == ST_RUN) && row_ready && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign eng_ctl.advance   = accept && (req_data.command == ledc_pkg::CMD_TICK);
   assign eng_ctl.set_dirty = accept && ((is_color && color_ok) || (is_pixel && idx_ok) ||
                                         is_clear ||
                                         (req_data.command == ledc_pkg::CMD_SHOW));

   // The read port fetches the engine's row while filling; otherwise it follows the
   // addressed LED, so a single-color write has its row in the following cycle, in ST_MERGE.
   assign rd_addr = (state_ff == ST_FILL) ? eng_stat.led_pos : req_data.led_index;

   always_comb begin
      case (mrg_slot_ff)
         2'd0:    merged_row = {rd_row[23:8], mrg_val_ff};
         2'd1:    merged_row = {rd_row[23:16], mrg_val_ff, rd_row[7:0]};
         2'd2:    merged_row = {mrg_val_ff, rd_row[15:0]};
         default: merged_row = rd_row;
      endcase
   end

   always_comb begin
      if (state_ff == ST_MERGE) begin
         wr_en   = 1'b1;
         wr_addr = mrg_idx_ff;
         wr_row  = merged_row;
      end else begin
         // Slot 0 holds green, slot 1 red and slot 2 blue, the wire order of the chain.
         wr_en   = accept && is_pixel && idx_ok;
         wr_addr = req_data.led_index;
         wr_row  = {req_data.blue, req_data.red, req_data.green};
      end
   end

   assign clr_en = accept && is_clear;

   always_comb begin
      state_in     = state_ff;
      row_ok_in    = row_ok_ff;
      row_pos_in   = row_pos_ff;
      cur_row_in   = cur_row_ff;
      mrg_idx_in   = mrg_idx_ff;
      mrg_slot_in  = mrg_slot_ff;
      mrg_val_in   = mrg_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.line_level  = eng_stat.line_level;
         rsp_data_in.write_error = write_err;
         rsp_data_in.busy_res    = eng_stat.busy;
         mrg_idx_in              = req_data.led_index;
         mrg_slot_in             = req_data.color_slot;
         mrg_val_in              = req_data.value;
         if (is_color || is_pixel || is_clear) begin
            row_ok_in = 1'b0;
         end
      end

      case (state_ff)
         ST_RUN: begin
            if (accept && is_color && color_ok) begin
               state_in = ST_MERGE;
            end else if (!row_ready) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cur_row_in = rd_row;
            row_pos_in = eng_stat.led_pos;
            row_ok_in  = 1'b1;
            state_in   = ST_RUN;
         end
         ST_MERGE: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         row_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= ledc_pkg::CFG_RESET;
      end else begin
         state_ff     <= state_in;
         row_ok_ff    <= row_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               ledc_pkg::REG_LED_COUNT:    cfg_ff.led_count    <= csr_wdata[8:0];
               ledc_pkg::REG_BIT_PERIOD:   cfg_ff.bit_period   <= csr_wdata[15:0];
               ledc_pkg::REG_ZERO_HIGH:    cfg_ff.zero_high    <= csr_wdata[15:0];
               ledc_pkg::REG_ONE_HIGH:     cfg_ff.one_high     <= csr_wdata[15:0];
               ledc_pkg::REG_LATCH_CYCLES: cfg_ff.latch_cycles <= csr_wdata[19:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      row_pos_ff  <= row_pos_in;
      cur_row_ff  <= cur_row_in;
      mrg_idx_ff  <= mrg_idx_in;
      mrg_slot_ff <= mrg_slot_in;
      mrg_val_ff  <= mrg_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ledc_pixel_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_row  (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_row  (wr_row),
      .clr_en  (clr_en),
      .clr_len (len)
   );

   ledc_pulse_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .ctl     (eng_ctl),
      .cur_row (cur_row_ff),
      .stat    (eng_stat)
   );

endmodule

### hw/rtl/ledc_pixel_store.sv
// Pixel store: one 24-bit row per LED in a synchronous memory plus a valid bit per row.
// Depends on ledc_pkg; rows that are not valid read as zero, which gives reset and clear-all.
module ledc_pixel_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ledc_pkg::LED_W-1:0]   rd_addr,
   output logic [ledc_pkg::ROW_W-1:0]   rd_row,
   input  logic                         wr_en,
   input  logic [ledc_pkg::LED_W-1:0]   wr_addr,
   input  logic [ledc_pkg::ROW_W-1:0]   wr_row,
   input  logic                         clr_en,
   input  logic [ledc_pkg::CNT_W-1:0]   clr_len
);

   logic [ledc_pkg::ROW_W-1:0] pixel_mem_ff [ledc_pkg::MAX_LEDS];
   logic [ledc_pkg::MAX_LEDS-1:0] row_valid_ff;
   logic [ledc_pkg::ROW_W-1:0] rd_row_ff;
   logic rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_mem_ff[wr_addr] <= wr_row;
      end
      rd_row_ff <= pixel_mem_ff[rd_addr];
      rd_ok_ff  <= row_valid_ff[rd_addr];
   end

   // Clear-all drops the valid bits of every row inside the chain at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         if (clr_en) begin
            for (int i = 0; i < ledc_pkg::MAX_LEDS; i++) begin
               if (ledc_pkg::CNT_W'(i) < clr_len) begin
                  row_valid_ff[i] <= 1'b0;
               end
            end
         end
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_row = rd_ok_ff ? rd_row_ff : '0;

endmodule

### hw/rtl/ledc_pulse_engine.sv
// Latch, idle and data phase machine with bit, byte, LED and tick counters.
// Depends on ledc_pkg; takes the current LED row from the top level.
module ledc_pulse_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  ledc_pkg::cfg_type           cfg,
   input  ledc_pkg::eng_ctl_type       ctl,
   input  logic [ledc_pkg::ROW_W-1:0]  cur_row,
   output ledc_pkg::eng_stat_type      stat
);

   typedef enum logic [1:0] {
      PH_LATCH,
      PH_IDLE,
      PH_DATA
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic                       dirty_ff, dirty_in;
   logic [ledc_pkg::LED_W-1:0] led_pos_ff, led_pos_in;
   logic [1:0]                 slot_ff, slot_in;
   logic [2:0]                 bit_ff, bit_in;
   logic [15:0]                ticks_ff, ticks_in;
   logic [19:0]                latch_ff, latch_in;

   logic [ledc_pkg::CNT_W-1:0]  len;
   logic [19:0]                 latch_sum;
   logic [16:0]                 tick_sum;
   logic [ledc_pkg::CNT_W-1:0]  pos_sum;
   logic                        pos_out;
   logic [ledc_pkg::BYTE_W-1:0] cur_byte;
   logic [15:0]                 high_ticks;

   assign len       = ledc_pkg::chain_len(cfg.led_count);
   assign latch_sum = latch_ff + 20'd1;
   assign tick_sum  = {1'b0, ticks_ff} + 17'd1;
   assign pos_sum   = {1'b0, led_pos_ff} + ledc_pkg::CNT_W'(1);
   assign pos_out   = {1'b0, led_pos_ff} >= len;

   always_comb begin
      case (slot_ff)
         2'd0:    cur_byte = cur_row[7:0];
         2'd1:    cur_byte = cur_row[15:8];
         2'd2:    cur_byte = cur_row[23:16];
         default: cur_byte = '0;
      endcase
      high_ticks = cur_byte[bit_ff] ? cfg.one_high : cfg.zero_high;
   end

   always_comb begin
      phase_in   = phase_ff;
      dirty_in   = dirty_ff;
      led_pos_in = led_pos_ff;
      slot_in    = slot_ff;
      bit_in     = bit_ff;
      ticks_in   = ticks_ff;
      latch_in   = latch_ff;
      if (ctl.advance) begin
         case (phase_ff)
            PH_LATCH: begin
               latch_in = latch_sum;
               if (latch_sum >= cfg.latch_cycles) begin
                  led_pos_in = '0;
                  slot_in    = '0;
                  bit_in     = 3'd7;
                  ticks_in   = '0;
                  dirty_in   = 1'b0;
                  phase_in   = dirty_ff ? PH_DATA : PH_IDLE;
               end
            end
            PH_IDLE: begin
               if (dirty_ff) begin
                  dirty_in = 1'b0;
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               if (pos_out) begin
                  phase_in   = PH_LATCH;
                  led_pos_in = '0;
                  slot_in    = '0;
                  bit_in     = 3'd7;
                  ticks_in   = '0;
                  latch_in   = '0;
               end else if (tick_sum < {1'b0, cfg.bit_period}) begin
                  ticks_in = tick_sum[15:0];
               end else begin
                  ticks_in = '0;
                  if (bit_ff != 3'd0) begin
                     bit_in = bit_ff - 3'd1;
                  end else begin
                     bit_in = 3'd7;
                     if (slot_ff != 2'd2) begin
                        slot_in = slot_ff + 2'd1;
                     end else begin
                        slot_in = '0;
                        if (pos_sum >= len) begin
                           // Last LED done: the latch follows.
                           phase_in   = PH_LATCH;
                           led_pos_in = '0;
                           latch_in   = '0;
                        end else begin
                           led_pos_in = pos_sum[ledc_pkg::LED_W-1:0];
                        end
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_LATCH;
            end
         endcase
      end
      if (ctl.set_dirty) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LATCH;
         dirty_ff   <= 1'b0;
         led_pos_ff <= '0;
         slot_ff    <= '0;
         bit_ff     <= 3'd7;
         ticks_ff   <= '0;
         latch_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         dirty_ff   <= dirty_in;
         led_pos_ff <= led_pos_in;
         slot_ff    <= slot_in;
         bit_ff     <= bit_in;
         ticks_ff   <= ticks_in;
         latch_ff   <= latch_in;
      end
   end

   assign stat.in_data    = (phase_ff == PH_DATA);
   assign stat.busy       = (phase_ff == PH_LATCH) || (phase_ff == PH_DATA);
   assign stat.led_pos    = led_pos_ff;
   assign stat.line_level = (phase_ff == PH_DATA) && !pos_out && (ticks_ff < high_ticks);

endmodule

### hw/rtl/ledc_checker.sv
// Port-level checker for the addressable LED chain driver, bound to the top level.
// Depends on ledc_pkg and on the port list of addressable_led_chain_driver_top.
module ledc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ledc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ledc_pkg::rsp_type rsp_data
);

   // Every accepted command yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transfer produced no result");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The line is only driven high while the chain is busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_level |-> rsp_data.busy_res)
      else $error("line high outside busy phases");

   // Only write commands can report an error.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      req_data.command != ledc_pkg::CMD_WRITE_COLOR &&
      req_data.command != ledc_pkg::CMD_WRITE_PIXEL |=> !rsp_data.write_error)
      else $error("write error on a non-write command");

endmodule

bind addressable_led_chain_driver_top ledc_checker u_ledc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
